FILE: src/eod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy onset detector package
// Shared widths, register indexes, reset values and the configuration and
// pipeline structs.
// ----------------------------------------------------------------------------
package eod_pkg;

  localparam int WINDOW_LENGTH_DEF = 512;

  localparam int SAMPLE_W   = 16;
  localparam int ENERGY_W   = 31;
  localparam int HOP_W      = 10;
  localparam int COUNT_W    = 20;
  localparam int SQ_W       = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_HOP_LENGTH = 2'd1,
    CFG_REFRACTORY = 2'd2,
    CFG_ACTIVATION = 2'd3
  } cfg_idx_t;

  localparam logic [ENERGY_W-1:0] THRESHOLD_RST  = 31'd53687091;
  localparam logic [HOP_W-1:0]    HOP_LENGTH_RST = 10'd256;
  localparam logic [COUNT_W-1:0]  REFRACTORY_RST = 20'd22050;
  localparam logic [COUNT_W-1:0]  ACTIVATION_RST = 20'd2205;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy_threshold;
    logic [HOP_W-1:0]    hop_length;
    logic [COUNT_W-1:0]  refractory_samples;
    logic [COUNT_W-1:0]  activation_samples;
  } cfg_t;

  // Squares of the sample leaving the window and the sample entering it.
  typedef struct packed {
    logic [SQ_W-1:0] old_sq;
    logic [SQ_W-1:0] new_sq;
  } sq_pair_t;

endpackage
`default_nettype wire

FILE: src/eod_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy onset detector channel interfaces
// Valid/ready channels for incoming samples and for per-sample results.
// ----------------------------------------------------------------------------
interface eod_in_if import eod_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface eod_out_if import eod_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hop_done;
  logic                onset;
  logic                pulse_level;
  logic [ENERGY_W-1:0] mean_energy;

  modport source (output valid, output hop_done, output onset, output pulse_level,
                  output mean_energy, input ready);
  modport sink   (input valid, input hop_done, input onset, input pulse_level,
                  input mean_energy, output ready);
endinterface
`default_nettype wire

FILE: src/eod_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy onset detector configuration registers
// Write-only register file; values are truncated to each register's width.
// ----------------------------------------------------------------------------
module eod_cfg import eod_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:  cfg_nxt.energy_threshold   = cfg_wdata[ENERGY_W-1:0];
        CFG_HOP_LENGTH: cfg_nxt.hop_length         = cfg_wdata[HOP_W-1:0];
        CFG_REFRACTORY: cfg_nxt.refractory_samples = cfg_wdata[COUNT_W-1:0];
        CFG_ACTIVATION: cfg_nxt.activation_samples = cfg_wdata[COUNT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_threshold   <= THRESHOLD_RST;
      cfg_r.hop_length         <= HOP_LENGTH_RST;
      cfg_r.refractory_samples <= REFRACTORY_RST;
      cfg_r.activation_samples <= ACTIVATION_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: src/eod_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy onset detector sample window
// Circular sample memory with a prefetched read of the oldest slot, and the
// squaring stage that feeds the running sum.
// ----------------------------------------------------------------------------
module eod_window import eod_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  eod_in_if.sink    in_ch,
  output logic      s1_valid,
  input  wire logic s1_ready,
  output sq_pair_t  s1_sq
);

  localparam int              PTR_W = $clog2(WINDOW_LENGTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(WINDOW_LENGTH - 1);

  logic [SAMPLE_W-1:0] mem [WINDOW_LENGTH];

  logic [PTR_W-1:0]    ptr_r;
  logic [PTR_W-1:0]    ptr_nxt;
  logic [PTR_W-1:0]    ptr_inc;
  logic [PTR_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_r;
  logic                filled_r;
  logic                filled_nxt;
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  sq_pair_t            sq_r;
  logic                accept;
  logic [SAMPLE_W-1:0] old_sample;

  function automatic logic [SQ_W-1:0] square_of(input logic [SAMPLE_W-1:0] raw);
    logic signed [2*SAMPLE_W-1:0] prod;
    prod = $signed(raw) * $signed(raw);
    return prod[SQ_W-1:0];
  endfunction

  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign ptr_inc = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
  assign rd_addr = accept ? ptr_inc : ptr_r;
  assign ptr_nxt = accept ? ptr_inc : ptr_r;

  // Until the pointer has wrapped once, the oldest slot was never written and
  // counts as a zero sample.
  assign filled_nxt   = filled_r || (accept && (ptr_r == LAST));
  assign old_sample   = filled_r ? rd_r : '0;
  assign s1_valid_nxt = accept ? 1'b1 : (s1_ready ? 1'b0 : s1_valid_r);

  // rd_r always holds the slot at ptr_r, which is the sample about to leave.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[ptr_r] <= in_ch.sample;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r.old_sq <= square_of(old_sample);
      sq_r.new_sq <= square_of(in_ch.sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      filled_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      ptr_r      <= ptr_nxt;
      filled_r   <= filled_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_sq    = sq_r;

endmodule
`default_nettype wire

FILE: src/eod_detect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy onset detector decision stage
// Running sum of squares, hop counter, threshold test, refractory and pulse
// counters, and the result register.
// ----------------------------------------------------------------------------
module eod_detect import eod_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      s1_valid,
  output logic           s1_ready,
  input  wire sq_pair_t  s1_sq,
  eod_out_if.source      out_ch
);

  localparam int SUM_W = $clog2(WINDOW_LENGTH) + ENERGY_W;
  localparam int SHIFT = $clog2(WINDOW_LENGTH + 1) - 1;

  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [HOP_W-1:0]    hop_count_r;
  logic [HOP_W-1:0]    hop_count_nxt;
  logic [HOP_W-1:0]    hop_count_inc;
  logic [HOP_W-1:0]    hop;
  logic [COUNT_W-1:0]  refr_r;
  logic [COUNT_W-1:0]  refr_nxt;
  logic [COUNT_W-1:0]  refr_base;
  logic [COUNT_W-1:0]  act_r;
  logic [COUNT_W-1:0]  act_nxt;
  logic [ENERGY_W-1:0] mean_full;
  logic                hop_hit;
  logic                fire;
  logic                advance;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                hop_done_r;
  logic                onset_r;
  logic                pulse_r;
  logic [ENERGY_W-1:0] mean_r;

  assign s1_ready = !out_valid_r || out_ch.ready;
  assign advance  = s1_valid && s1_ready;

  always_comb begin
    // A hop length of zero behaves as one.
    hop           = (cfg.hop_length == '0) ? HOP_W'(1) : cfg.hop_length;
    hop_count_inc = hop_count_r + 1'b1;
    hop_hit       = (hop_count_inc >= hop) || (hop_count_inc == '0);
    hop_count_nxt = hop_hit ? '0 : hop_count_inc;

    sum_nxt   = sum_r - SUM_W'(s1_sq.old_sq) + SUM_W'(s1_sq.new_sq);
    mean_full = sum_nxt[SHIFT +: ENERGY_W];

    fire = hop_hit && (mean_full >= cfg.energy_threshold) && (refr_r == '0);

    // The reload at an onset is lowered by the hop in the same transaction.
    refr_base = fire ? cfg.refractory_samples : refr_r;
    if (hop_hit) begin
      refr_nxt = (refr_base > COUNT_W'(hop)) ? refr_base - COUNT_W'(hop) : '0;
    end else begin
      refr_nxt = refr_r;
    end

    act_nxt = (act_r != '0) ? act_r - 1'b1 : act_r;
    if (fire) begin
      act_nxt = cfg.activation_samples;
    end

    out_valid_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hop_done_r <= hop_hit;
      onset_r    <= fire;
      pulse_r    <= (act_nxt != '0);
      mean_r     <= hop_hit ? mean_full : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      hop_count_r <= '0;
      refr_r      <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        sum_r       <= sum_nxt;
        hop_count_r <= hop_count_nxt;
        refr_r      <= refr_nxt;
        act_r       <= act_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hop_done    = hop_done_r;
  assign out_ch.onset       = onset_r;
  assign out_ch.pulse_level = pulse_r;
  assign out_ch.mean_energy = mean_r;

endmodule
`default_nettype wire

FILE: src/energy_onset_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// Samples pass the squaring-stage register, then the result register.
// Throughput: one sample per cycle barring stalls, set by the running-sum update.
// A stalled result register still lets one more sample enter the squaring stage.
// Reset is synchronous and active low; it clears all counters and the running
// sum and resets the configuration; the window memory needs no clearing pass.
// ----------------------------------------------------------------------------
// Energy onset detector
// Windowed mean energy with threshold, refractory dead time and onset pulse.
// ----------------------------------------------------------------------------
module energy_onset_detector import eod_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  eod_in_if.sink                     in_ch,
  eod_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg;
  logic     s1_valid;
  logic     s1_ready;
  sq_pair_t s1_sq;

  eod_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  eod_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_sq    (s1_sq)
  );

  eod_detect #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_detect (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_sq    (s1_sq),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

FILE: src/eod_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy onset detector port checker
// Checks result consistency and output handshake behavior at the top level.
// ----------------------------------------------------------------------------
module eod_port_checker import eod_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                hop_done,
  input wire logic                onset,
  input wire logic                pulse_level,
  input wire logic [ENERGY_W-1:0] mean_energy
);

  // An onset can only be decided at an energy evaluation.
  a_onset_at_hop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && onset |-> hop_done)
    else $error("onset reported without a hop");

  // Between hops the mean is forced to zero.
  a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hop_done |-> (mean_energy == '0))
    else $error("nonzero mean energy outside a hop");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hop_done) && $stable(onset)
      && $stable(pulse_level) && $stable(mean_energy))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind energy_onset_detector eod_port_checker u_eod_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .hop_done    (out_ch.hop_done),
  .onset       (out_ch.onset),
  .pulse_level (out_ch.pulse_level),
  .mean_energy (out_ch.mean_energy)
);
`default_nettype wire

FILE: sim/eod_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy onset detector checker
// Watches the sample, result and configuration ports. It keeps its own copy
// of the window, running sum, counters and registers, predicts one result per
// sample transaction and compares each result transaction with the oldest
// prediction.
// ----------------------------------------------------------------------------
module eod_checker import eod_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  eod_in_if                     in_ch,
  eod_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  // The mean divides by the largest power of two not above the window length.
  localparam int WIN_SHIFT = $clog2(WINDOW_LENGTH + 1) - 1;

  typedef struct packed {
    logic                hop_done;
    logic                onset;
    logic                pulse_level;
    logic [ENERGY_W-1:0] mean_energy;
  } onset_result_t;

  logic [SAMPLE_W-1:0] history [WINDOW_LENGTH];
  logic [63:0]         energy_sum;
  int unsigned         slot;
  logic [HOP_W-1:0]    since_hop;
  logic [COUNT_W-1:0]  dead_left;
  logic [COUNT_W-1:0]  pulse_left;
  cfg_t                regs;
  onset_result_t       expected_q [$];
  int                  mismatches = 0;

  function automatic logic [31:0] square_of_sample(input logic [SAMPLE_W-1:0] raw);
    logic [31:0] mag;
    mag = raw[SAMPLE_W-1] ? 32'h10000 - 32'(raw) : 32'(raw);
    return mag * mag;
  endfunction

  function automatic onset_result_t step_detector(input logic [SAMPLE_W-1:0] raw);
    onset_result_t    res;
    logic [HOP_W-1:0] hop;
    res = '0;
    hop = (regs.hop_length == '0) ? HOP_W'(1) : regs.hop_length;
    energy_sum = energy_sum - 64'(square_of_sample(history[slot]))
                 + 64'(square_of_sample(raw));
    history[slot] = raw;
    slot = (slot + 1) % WINDOW_LENGTH;
    if (pulse_left != '0) pulse_left = pulse_left - 1'b1;
    // The hop counter wraps at its width, and a wrap to zero also closes a hop.
    since_hop = since_hop + 1'b1;
    if (since_hop >= hop || since_hop == '0) begin
      since_hop = '0;
      res.hop_done = 1'b1;
      res.mean_energy = ENERGY_W'(energy_sum >> WIN_SHIFT);
      if (res.mean_energy >= regs.energy_threshold && dead_left == '0) begin
        res.onset  = 1'b1;
        dead_left  = regs.refractory_samples;
        pulse_left = regs.activation_samples;
      end
      dead_left = (dead_left > COUNT_W'(hop)) ? dead_left - COUNT_W'(hop) : '0;
    end
    res.pulse_level = (pulse_left != '0);
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    onset_result_t exp_res;
    if (!rst_n) begin
      foreach (history[i]) history[i] = '0;
      energy_sum = '0;
      slot       = 0;
      since_hop  = '0;
      dead_left  = '0;
      pulse_left = '0;
      regs       = '{THRESHOLD_RST, HOP_LENGTH_RST, REFRACTORY_RST, ACTIVATION_RST};
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no sample transaction pending");
          mismatches++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_ch.hop_done !== exp_res.hop_done) begin
            $error("hop_done: expected %0d, got %0d", exp_res.hop_done, out_ch.hop_done);
            mismatches++;
          end
          if (out_ch.onset !== exp_res.onset) begin
            $error("onset: expected %0d, got %0d", exp_res.onset, out_ch.onset);
            mismatches++;
          end
          if (out_ch.pulse_level !== exp_res.pulse_level) begin
            $error("pulse_level: expected %0d, got %0d", exp_res.pulse_level,
                   out_ch.pulse_level);
            mismatches++;
          end
          if (out_ch.mean_energy !== exp_res.mean_energy) begin
            $error("mean_energy: expected %0d, got %0d", exp_res.mean_energy,
                   out_ch.mean_energy);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD:  regs.energy_threshold   = cfg_wdata[ENERGY_W-1:0];
          CFG_HOP_LENGTH: regs.hop_length         = cfg_wdata[HOP_W-1:0];
          CFG_REFRACTORY: regs.refractory_samples = cfg_wdata[COUNT_W-1:0];
          CFG_ACTIVATION: regs.activation_samples = cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.insert(expected_q.size(), step_detector(in_ch.sample));
      end
    end
    fail_count <= mismatches;
    pending    <= expected_q.size();
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy onset detector testbench
// Drives samples and register settings with random gaps and result stalls:
// a short directed part for threshold equality, zero and lowered hop length,
// refractory reload and pulse restart, then random phases built from silent,
// quiet, loud and full-scale segments under varied settings.
// ----------------------------------------------------------------------------
module tb_top;
  import eod_pkg::*;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int RANDOM_PHASES    = 12;
  localparam int FULL_SCALE_ITEMS = 530;
  localparam int PHASE_ITEMS      = 116;

  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;

  typedef enum int {SEG_SILENT, SEG_QUIET, SEG_LOUD, SEG_FULL_SCALE} seg_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    cycle_count = 0;
  bit                    gaps_on = 1'b1;
  bit                    stalls_on = 1'b1;

  eod_in_if  in_ch ();
  eod_out_if out_ch ();

  energy_onset_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  eod_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[energy_onset_detector] ERROR");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = stalls_on ? $urandom_range(0, 13) : 0;
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Bits above the hop, refractory and activation widths carry junk; the block must drop them.
  task automatic apply_setting(input logic [ENERGY_W-1:0] thr, input logic [HOP_W-1:0] hop,
                               input logic [COUNT_W-1:0] refr, input logic [COUNT_W-1:0] act);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_HOP_LENGTH, {21'($urandom), hop});
    write_reg(CFG_REFRACTORY, {11'($urandom), refr});
    write_reg(CFG_ACTIVATION, {11'($urandom), act});
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits until every sample transaction has its result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] segment_sample(input seg_kind_t kind);
    case (kind)
      SEG_SILENT:     return '0;
      SEG_QUIET:      return $signed(16'($urandom_range(0, 511))) - 16'sd256;
      SEG_LOUD:       return 16'($urandom);
      default:        return $urandom_range(0, 1) ? FULL_NEG : FULL_POS;
    endcase
  endfunction

  initial begin : stimulus
    seg_kind_t           kind;
    int                  seg_left;
    int                  items;
    int                  phase;
    logic [ENERGY_W-1:0] thr;
    logic [HOP_W-1:0]    hop;
    logic [COUNT_W-1:0]  refr;
    logic [COUNT_W-1:0]  act;

    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_THRESHOLD;
    cfg_wdata    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // One full-scale sample in an empty window gives a mean exactly at this
    // threshold. Hop length zero makes every sample a hop.
    apply_setting(31'd2097024, 10'd0, 20'd0, 20'd0);
    send_sample(FULL_POS);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(FULL_NEG);
    drain();

    // Short dead time and a longer pulse, so a new onset restarts the pulse.
    apply_setting(31'd0, 10'd1, 20'd3, 20'd5);
    send_sample(16'sd1);
    send_sample(-16'sd2);
    send_sample(16'sh4000);
    send_sample(16'shC000);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(16'sd0);
    send_sample(16'sd1);
    drain();

    apply_setting(31'h7FFFFFFF, 10'h3FF, 20'hFFFFF, 20'hFFFFF);
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
    send_sample(16'sh00FF);
    send_sample(16'shFF00);
    drain();

    // The hop counter is already past the new, shorter hop length.
    apply_setting(31'h7FFFFFFF, 10'd2, 20'hFFFFF, 20'hFFFFF);
    send_sample(16'sh1234);
    send_sample(-16'sh1234);
    send_sample(16'sd7);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      gaps_on   = ($urandom_range(0, 2) != 0);
      stalls_on = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = 31'h40000000;
        2:       thr = 31'h7FFFFFFF;
        3:       thr = $urandom_range(0, 32'h40000000);
        default: thr = $urandom_range(0, 32'h10000000);
      endcase
      case ($urandom_range(0, 5))
        0:       hop = '0;
        1:       hop = 10'h3FF;
        2:       hop = 10'd512;
        default: hop = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 3))
        0:       refr = '0;
        1:       refr = 20'hFFFFF;
        default: refr = $urandom_range(0, 200);
      endcase
      case ($urandom_range(0, 3))
        0:       act = '0;
        1:       act = 20'hFFFFF;
        default: act = $urandom_range(0, 200);
      endcase
      // A whole window of the most negative sample reaches the top mean exactly.
      if (phase == 0) begin
        thr = 31'h40000000;
        hop = $urandom_range(1, 8);
      end
      apply_setting(thr, hop, refr, act);
      items    = (phase == 0) ? FULL_SCALE_ITEMS : PHASE_ITEMS;
      seg_left = 0;
      kind     = SEG_SILENT;
      repeat (items) begin
        if (phase == 0) begin
          send_sample(FULL_NEG);
        end else begin
          if (seg_left == 0) begin
            kind     = seg_kind_t'($urandom_range(0, 3));
            seg_left = $urandom_range(1, 48);
          end
          send_sample(segment_sample(kind));
          seg_left--;
        end
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("[energy_onset_detector] OK");
    end else begin
      $display("[energy_onset_detector] ERROR");
    end
    $finish;
  end

endmodule
